// ===== rtl/core/rbc_pkg.sv =====
`timescale 1ns / 1ps
package rbc_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'd0,
    MODE_MULTIPLY = 3'd1,
    MODE_SCREEN   = 3'd2,
    MODE_OVERLAY  = 3'd3,
    MODE_DARKEN   = 3'd4,
    MODE_LIGHTEN  = 3'd5
  } mode_t;

  localparam logic [7:0] REG_BLEND_MODE    = 8'd0;
  localparam logic [7:0] REG_LAYER_OPACITY = 8'd1;
  localparam logic [8:0] OPACITY_FULL      = 9'd256;

  // Everything one pixel carries down the pipeline; each stage fills its own fields.
  typedef struct packed {
    logic [2:0][7:0]  sc;
    logic [2:0][7:0]  dc;
    logic [7:0]       sa;
    logic [7:0]       da;
    logic [2:0]       mode;
    logic [8:0]       op;
    logic [7:0]       ea;
    logic [7:0]       inv;
    logic [2:0][15:0] pm;
    logic [2:0][14:0] po;
    logic [2:0][15:0] dd;
    logic [2:0][7:0]  b;
    logic [2:0][23:0] ddi;
    logic [15:0]      ai;
    logic [7:0]       oa;
    logic [2:0][15:0] be;
    logic [2:0][15:0] t;
    logic [2:0][16:0] rem;
    logic [2:0][7:0]  q;
    logic [2:0]       ovf;
  } pix_t;

  // Floor of x/255 for x below 2^24: the reciprocal estimate is at most one low.
  function automatic logic [16:0] div255(input logic [24:0] x);
    logic [32:0] prod;
    logic [16:0] qe;
    logic [25:0] back;
    logic [25:0] r;
    prod = {x, 8'd0} + {8'd0, x};
    qe   = prod[32:16];
    back = {1'b0, qe, 8'd0} - {9'd0, qe};
    r    = {1'b0, x} - back;
    if (r >= 26'd255) begin
      qe = qe + 17'd1;
    end
    return qe;
  endfunction

endpackage

// ===== rtl/core/rbc_blend.sv =====
`timescale 1ns / 1ps
module rbc_blend
  import rbc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_v,
  input  pix_t in_p,
  output logic out_v,
  output pix_t out_p
);

  logic v1_r, v2_r, v3_r, v4_r;
  pix_t s1_r, s2_r, s3_r, s4_r;
  pix_t s1_nxt, s2_nxt, s3_nxt, s4_nxt;

  // Stage 1: effective alpha and the raw channel products.
  always_comb begin
    logic [16:0] eprod;
    logic [7:0]  a, bb;
    s1_nxt = in_p;
    eprod = {1'b0, in_p.sa} * in_p.op + 17'd128;
    s1_nxt.ea = eprod[15:8];
    for (int c = 0; c < 3; c++) begin
      s1_nxt.pm[c] = in_p.sc[c] * in_p.dc[c];
      if (in_p.dc[c] < 8'd128) begin
        a  = in_p.sc[c];
        bb = in_p.dc[c];
      end else begin
        a  = 8'd255 - in_p.sc[c];
        bb = 8'd255 - in_p.dc[c];
      end
      s1_nxt.po[c] = 15'(a * bb);
      s1_nxt.dd[c] = in_p.dc[c] * in_p.da;
    end
  end

  // Stage 2: blended channel and the destination weights.
  always_comb begin
    logic [16:0] m, o;
    s2_nxt = s1_r;
    s2_nxt.inv = 8'd255 - s1_r.ea;
    s2_nxt.ai  = s1_r.da * s2_nxt.inv;
    for (int c = 0; c < 3; c++) begin
      m = div255({9'd0, s1_r.pm[c]} + 25'd127);
      o = div255({9'd0, s1_r.po[c], 1'b0} + 25'd127);
      s2_nxt.ddi[c] = s1_r.dd[c] * s2_nxt.inv;
      unique case (s1_r.mode)
        MODE_MULTIPLY: s2_nxt.b[c] = m[7:0];
        MODE_SCREEN:   s2_nxt.b[c] = s1_r.sc[c] + s1_r.dc[c] - m[7:0];
        MODE_OVERLAY:  s2_nxt.b[c] = (s1_r.dc[c] < 8'd128) ? o[7:0] : 8'd255 - o[7:0];
        MODE_DARKEN:   s2_nxt.b[c] = (s1_r.sc[c] < s1_r.dc[c]) ? s1_r.sc[c] : s1_r.dc[c];
        MODE_LIGHTEN:  s2_nxt.b[c] = (s1_r.sc[c] > s1_r.dc[c]) ? s1_r.sc[c] : s1_r.dc[c];
        default:       s2_nxt.b[c] = s1_r.sc[c];
      endcase
    end
  end

  // Stage 3: output alpha and the two color terms.
  always_comb begin
    logic [16:0] da_term;
    logic [16:0] tq;
    s3_nxt = s2_r;
    da_term = div255({9'd0, s2_r.ai} + 25'd127);
    s3_nxt.oa = s2_r.ea + da_term[7:0];
    for (int c = 0; c < 3; c++) begin
      s3_nxt.be[c] = s2_r.b[c] * s2_r.ea;
      tq = div255({1'b0, s2_r.ddi[c]});
      s3_nxt.t[c] = tq[15:0];
    end
  end

  // Stage 4: numerator with the rounding half of the divisor.
  always_comb begin
    s4_nxt = s3_r;
    for (int c = 0; c < 3; c++) begin
      s4_nxt.rem[c] = {1'b0, s3_r.be[c]} + {1'b0, s3_r.t[c]} + {10'd0, s3_r.oa[7:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign out_v = v4_r;
  assign out_p = s4_r;

  a_oa_covers_ea: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && (s3_r.ea != 8'd0) |-> (s3_r.oa >= s3_r.ea))
    else $error("output alpha below effective alpha");

  a_inv_sum: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> ({1'b0, s2_r.ea} + {1'b0, s2_r.inv} == 9'd255))
    else $error("inverse alpha inconsistent");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !en |=> v4_r && $stable(s4_r))
    else $error("stage four changed while held");

endmodule

// ===== rtl/core/rbc_div.sv =====
`timescale 1ns / 1ps
module rbc_div
  import rbc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_v,
  input  pix_t in_p,
  output logic out_v,
  output pix_t out_p
);

  localparam int Stages = 4;

  logic [Stages-1:0] v_r;
  pix_t st_r  [Stages];
  pix_t st_nxt[Stages];

  // Restoring division by the output alpha, two quotient bits per stage.
  for (genvar g = 0; g < Stages; g++) begin : g_stage
    always_comb begin
      pix_t        p;
      logic [16:0] dv;
      p = (g == 0) ? in_p : st_r[(g == 0) ? 0 : g - 1];
      for (int c = 0; c < 3; c++) begin
        if (g == 0) begin
          p.q[c]   = 8'd0;
          p.ovf[c] = p.rem[c] >= {1'b0, p.oa, 8'd0};
        end
        for (int j = 0; j < 2; j++) begin
          dv = {9'd0, p.oa} << (7 - 2 * g - j);
          if (p.rem[c] >= dv) begin
            p.rem[c] = p.rem[c] - dv;
            p.q[c][7 - 2 * g - j] = 1'b1;
          end
        end
      end
      st_nxt[g] = p;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= (g == 0) ? in_v : v_r[(g == 0) ? 0 : g - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g] <= st_nxt[g];
      end
    end
  end

  assign out_v = v_r[Stages-1];
  assign out_p = st_r[Stages-1];

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[Stages-1] && (st_r[Stages-1].ea != 8'd0) && (st_r[Stages-1].ovf == 3'd0) |->
      (st_r[Stages-1].rem[0] < {9'd0, st_r[Stages-1].oa}) &&
      (st_r[Stages-1].rem[1] < {9'd0, st_r[Stages-1].oa}) &&
      (st_r[Stages-1].rem[2] < {9'd0, st_r[Stages-1].oa}))
    else $error("division remainder not reduced");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && (st_r[0].ea != 8'd0) |-> (st_r[0].oa != 8'd0))
    else $error("zero output alpha in divide path");

  a_valid_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en && v_r[0] |=> v_r[1])
    else $error("valid lost between divide stages");

endmodule

// ===== rtl/core/rgba_blend_mode_compositor.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  src and dst RGBA, 8 bits each
// out_      output     out_valid/out_stall composited RGBA, changed
// cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One pixel is accepted per cycle unless the output stalls. Pipeline: input reg,
// four blend stages, four divider stages at two quotient bits each, output reg.
// Reset is synchronous and clears all valid bits and sets the configuration to
// normal mode at full opacity. When a valid output is stalled the whole pipeline
// holds and in_stall rises, so no transaction is lost or repeated.
module rgba_blend_mode_compositor
  import rbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_src_red,
  input  logic [7:0] in_src_green,
  input  logic [7:0] in_src_blue,
  input  logic [7:0] in_src_alpha,
  input  logic [7:0] in_dst_red,
  input  logic [7:0] in_dst_green,
  input  logic [7:0] in_dst_blue,
  input  logic [7:0] in_dst_alpha,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic       out_changed,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic [2:0] mode_r;
  logic [8:0] opacity_r;
  logic       en;
  logic       in_v_r;
  pix_t       in_p_r;
  pix_t       in_p_nxt;
  logic       bl_v, dv_v;
  pix_t       bl_p, dv_p;
  logic       out_valid_r;
  logic [2:0][7:0] out_c_r, out_c_nxt;
  logic [7:0] out_a_r, out_a_nxt;
  logic       changed_r, changed_nxt;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NORMAL;
      opacity_r <= OPACITY_FULL;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_BLEND_MODE) begin
        mode_r <= cfg_data[2:0];
      end else if (cfg_index == REG_LAYER_OPACITY) begin
        opacity_r <= cfg_data;
      end
    end
  end

  always_comb begin
    in_p_nxt = '0;
    in_p_nxt.sc[0] = in_src_red;
    in_p_nxt.sc[1] = in_src_green;
    in_p_nxt.sc[2] = in_src_blue;
    in_p_nxt.sa    = in_src_alpha;
    in_p_nxt.dc[0] = in_dst_red;
    in_p_nxt.dc[1] = in_dst_green;
    in_p_nxt.dc[2] = in_dst_blue;
    in_p_nxt.da    = in_dst_alpha;
    in_p_nxt.mode  = mode_r;
    in_p_nxt.op    = (opacity_r > OPACITY_FULL) ? OPACITY_FULL : opacity_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (en) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_p_r <= in_p_nxt;
    end
  end

  rbc_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_v_r),
    .in_p  (in_p_r),
    .out_v (bl_v),
    .out_p (bl_p)
  );

  rbc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (bl_v),
    .in_p  (bl_p),
    .out_v (dv_v),
    .out_p (dv_p)
  );

  // Transparent source and transparent destination bypass the blended result.
  always_comb begin
    if (dv_p.ea == 8'd0) begin
      out_c_nxt   = dv_p.dc;
      out_a_nxt   = dv_p.da;
      changed_nxt = 1'b0;
    end else if (dv_p.da == 8'd0) begin
      out_c_nxt   = dv_p.sc;
      out_a_nxt   = dv_p.ea;
      changed_nxt = 1'b1;
    end else begin
      for (int c = 0; c < 3; c++) begin
        out_c_nxt[c] = dv_p.ovf[c] ? 8'd255 : dv_p.q[c];
      end
      out_a_nxt   = dv_p.oa;
      changed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_c_r   <= out_c_nxt;
      out_a_r   <= out_a_nxt;
      changed_r <= changed_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_red     = out_c_r[0];
  assign out_green   = out_c_r[1];
  assign out_blue    = out_c_r[2];
  assign out_alpha   = out_a_r;
  assign out_changed = changed_r;

  a_stall_freezes_front: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && in_stall |=> in_v_r && $stable(in_p_r))
    else $error("input register changed during stall");

  a_opacity_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r |-> (in_p_r.op <= OPACITY_FULL))
    else $error("opacity not saturated");

  a_passthrough_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
    en && dv_v && (dv_p.ea == 8'd0) |=> out_valid_r && !changed_r)
    else $error("pass-through pixel flagged as changed");

endmodule
